FILE: src/mv2fp_pkg.sv
// ----------------------------------------------------------------------------
// mv2fp_pkg
// Shared types, constants and the CRC step of the MAVLink v2 frame packer.
// ----------------------------------------------------------------------------
`default_nettype none

package mv2fp_pkg;

  localparam logic [7:0]  MAGIC_BYTE         = 8'hFD;
  localparam logic [15:0] CRC_INIT           = 16'hFFFF;
  localparam logic [7:0]  SYSTEM_ID_RESET    = 8'd2;
  localparam logic [7:0]  COMPONENT_ID_RESET = 8'd100;
  localparam int          QUEUE_DEPTH_DEF    = 2;

  localparam logic REG_SYSTEM_ID    = 1'b0;
  localparam logic REG_COMPONENT_ID = 1'b1;

  typedef logic [3:0] slot_t;

  localparam slot_t SLOT_MAGIC    = 4'd0;
  localparam slot_t SLOT_LEN      = 4'd1;
  localparam slot_t SLOT_INCOMPAT = 4'd2;
  localparam slot_t SLOT_COMPAT   = 4'd3;
  localparam slot_t SLOT_SEQ      = 4'd4;
  localparam slot_t SLOT_SYSID    = 4'd5;
  localparam slot_t SLOT_COMPID   = 4'd6;
  localparam slot_t SLOT_MSG0     = 4'd7;
  localparam slot_t SLOT_MSG1     = 4'd8;
  localparam slot_t SLOT_MSG2     = 4'd9;
  localparam slot_t SLOT_DATA     = 4'd10;
  localparam slot_t SLOT_CRC_LO   = 4'd11;
  localparam slot_t SLOT_CRC_HI   = 4'd12;

  // One classified input word as the back end sees it.
  typedef struct packed {
    logic        hdr;
    logic        data_en;
    logic        last;
    logic [7:0]  len;
    logic [23:0] msg_id;
    logic [7:0]  extra;
    logic [7:0]  data;
    logic [7:0]  seq;
  } entry_t;

  function automatic logic [15:0] crc_take(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

`default_nettype wire

FILE: src/mv2fp_front.sv
// ----------------------------------------------------------------------------
// mv2fp_front
// Accepts input words, tracks frame position and sequence number, and
// classifies each word for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mv2fp_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [23:0]         message_id,
  input  wire logic [7:0]          payload_length,
  input  wire logic [7:0]          crc_extra_byte,
  input  wire logic [7:0]          payload_byte,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output mv2fp_pkg::entry_t        push_entry
);
  import mv2fp_pkg::*;

  logic       inside_frame;
  logic [7:0] bytes_remaining;
  logic [7:0] frame_sequence;
  logic       accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    push_entry.hdr     = !inside_frame;
    push_entry.data_en = inside_frame || (payload_length != 8'd0);
    push_entry.last    = inside_frame ? (bytes_remaining == 8'd1)
                                      : (payload_length <= 8'd1);
    push_entry.len     = payload_length;
    push_entry.msg_id  = message_id;
    push_entry.extra   = crc_extra_byte;
    push_entry.data    = payload_byte;
    push_entry.seq     = frame_sequence;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame    <= 1'b0;
      bytes_remaining <= 8'd0;
      frame_sequence  <= 8'd0;
    end else if (accept) begin
      if (push_entry.last) begin
        inside_frame   <= 1'b0;
        frame_sequence <= frame_sequence + 8'd1;
      end else begin
        inside_frame <= 1'b1;
      end
      bytes_remaining <= inside_frame ? bytes_remaining - 8'd1 : payload_length - 8'd1;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (accept && push_entry.last) |=> (frame_sequence == $past(frame_sequence) + 8'd1))
    else $error("sequence number did not advance at frame end");
  assert property (@(posedge clk) disable iff (rst)
    (accept && !push_entry.last) |=> inside_frame)
    else $error("frame not open after a non-final word");
`endif

endmodule

`default_nettype wire

FILE: src/mv2fp_queue.sv
// ----------------------------------------------------------------------------
// mv2fp_queue
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mv2fp_queue #(
  parameter int DEPTH = mv2fp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire mv2fp_pkg::entry_t   push_entry,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output mv2fp_pkg::entry_t        pop_entry
);
  import mv2fp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = store[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

FILE: src/mv2fp_back.sv
// ----------------------------------------------------------------------------
// mv2fp_back
// Emits the frame bytes of each queued word, runs the CRC and holds the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mv2fp_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          system_id,
  input  wire logic [7:0]          component_id,
  input  wire logic                pop_valid,
  output logic                     pop_ready,
  input  wire mv2fp_pkg::entry_t   pop_entry,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     out_last
);
  import mv2fp_pkg::*;

  logic        started;
  slot_t       slot;
  slot_t       slot_cur;
  slot_t       slot_next;
  logic        done;
  logic        step;
  logic [15:0] crc;
  logic [15:0] crc_final;
  logic [7:0]  extra_l;
  logic [7:0]  byte_cur;

  assign slot_cur  = started ? slot : (pop_entry.hdr ? SLOT_MAGIC : SLOT_DATA);
  assign step      = pop_valid && (!out_valid || out_ready);
  assign pop_ready = step && done;
  assign crc_final = crc_take(crc, extra_l);

  always_comb begin
    slot_next = slot_cur + 4'd1;
    done      = 1'b0;
    case (slot_cur)
      SLOT_MSG2: begin
        if (pop_entry.data_en) begin
          slot_next = SLOT_DATA;
        end else if (pop_entry.last) begin
          slot_next = SLOT_CRC_LO;
        end else begin
          done = 1'b1;
        end
      end
      SLOT_DATA: begin
        done = !pop_entry.last;
      end
      SLOT_CRC_HI: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (slot_cur)
      SLOT_MAGIC:    byte_cur = MAGIC_BYTE;
      SLOT_LEN:      byte_cur = pop_entry.len;
      SLOT_INCOMPAT: byte_cur = 8'h00;
      SLOT_COMPAT:   byte_cur = 8'h00;
      SLOT_SEQ:      byte_cur = pop_entry.seq;
      SLOT_SYSID:    byte_cur = system_id;
      SLOT_COMPID:   byte_cur = component_id;
      SLOT_MSG0:     byte_cur = pop_entry.msg_id[7:0];
      SLOT_MSG1:     byte_cur = pop_entry.msg_id[15:8];
      SLOT_MSG2:     byte_cur = pop_entry.msg_id[23:16];
      SLOT_DATA:     byte_cur = pop_entry.data;
      SLOT_CRC_LO:   byte_cur = crc_final[7:0];
      SLOT_CRC_HI:   byte_cur = crc[15:8];
      default:       byte_cur = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      slot      <= SLOT_MAGIC;
      out_valid <= 1'b0;
      crc       <= CRC_INIT;
      extra_l   <= 8'h00;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
        started   <= !done;
        slot      <= slot_next;
        case (slot_cur)
          SLOT_MAGIC: begin
            crc     <= CRC_INIT;
            extra_l <= pop_entry.extra;
          end
          SLOT_CRC_LO: crc <= crc_final;
          SLOT_CRC_HI: crc <= CRC_INIT;
          default:     crc <= crc_take(crc, byte_cur);
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte <= byte_cur;
      out_last <= (slot_cur == SLOT_CRC_HI);
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (step && slot_cur == SLOT_CRC_HI) |=> (out_valid && out_last && crc == CRC_INIT))
    else $error("frame end not marked or CRC not reset");
`endif

endmodule

`default_nettype wire

FILE: src/mavlink_v2_frame_packer.sv
// ----------------------------------------------------------------------------
// mavlink_v2_frame_packer
// Streams payload bytes into MAVLink v2 frames with CRC-16/MCRF4XX.
//
// Each input word carries one payload byte; the first word of a frame also
// carries the message id, payload length and CRC extra byte. That word yields
// the ten header bytes and its payload byte (none for a zero-length frame),
// and the last word of a frame is followed by the two CRC bytes, low first,
// with tlast on the high byte. The output runs at one byte per cycle
// while words are queued and the receiver is ready. The back end has a
// single-byte output register; a queue of QUEUE_DEPTH entries (two by
// default) lets the input take words while header and CRC bytes go out.
// ----------------------------------------------------------------------------
`default_nettype none

module mavlink_v2_frame_packer #(
  parameter int QUEUE_DEPTH = mv2fp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // message_id[23:0], payload_length[31:24], crc_extra_byte[39:32],
  // payload_byte[47:40]
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // frame_byte[7:0]
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import mv2fp_pkg::*;

  logic   [7:0] system_id;
  logic   [7:0] component_id;
  logic         push_valid;
  logic         push_ready;
  entry_t       push_entry;
  logic         pop_valid;
  logic         pop_ready;
  entry_t       pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      system_id    <= SYSTEM_ID_RESET;
      component_id <= COMPONENT_ID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYSTEM_ID:    system_id    <= cfg_data;
        REG_COMPONENT_ID: component_id <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mv2fp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .message_id     (s_axis_tdata[23:0]),
    .payload_length (s_axis_tdata[31:24]),
    .crc_extra_byte (s_axis_tdata[39:32]),
    .payload_byte   (s_axis_tdata[47:40]),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_entry     (push_entry)
  );

  mv2fp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  mv2fp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .system_id    (system_id),
    .component_id (component_id),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_byte     (m_axis_tdata),
    .out_last     (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the MAVLink v2 frame packer.
//
// Input words are driven as a stream and each accepted word is run through a
// frame predictor that builds the header, payload and CRC-16/MCRF4XX bytes
// the block has to emit. Output words are compared in order against that
// list. A short table of directed words comes first, followed by random
// frames under three idle patterns, one long receiver hold-off and several
// system and component id settings.
// ----------------------------------------------------------------------------
module tb_top;
  import mv2fp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [7:0] value;
    logic       ends;
  } frame_byte_t;

  typedef struct {
    logic [23:0]      msg;
    logic [7:0]       len;
    logic [7:0]       extra;
    logic [7:0]       data;
    bit               typed;
    logic [0:9][7:0]  hdr;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 13;

  // A typed row carries the ten header bytes it must produce.
  stim_row_t directed [DIRECTED_ROWS] = '{
    '{24'h000000, 8'h00, 8'h00, 8'hAA, 1'b1,
      {8'hFD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h64, 8'h00, 8'h00, 8'h00}},
    '{24'hFFFFFF, 8'h00, 8'hFF, 8'h55, 1'b1,
      {8'hFD, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h64, 8'hFF, 8'hFF, 8'hFF}},
    '{24'h123456, 8'h01, 8'h5A, 8'hFF, 1'b1,
      {8'hFD, 8'h01, 8'h00, 8'h00, 8'h02, 8'h02, 8'h64, 8'h56, 8'h34, 8'h12}},
    '{24'h000000, 8'h01, 8'hFF, 8'h00, 1'b1,
      {8'hFD, 8'h01, 8'h00, 8'h00, 8'h03, 8'h02, 8'h64, 8'h00, 8'h00, 8'h00}},
    '{24'hABCDEF, 8'h03, 8'h00, 8'h80, 1'b1,
      {8'hFD, 8'h03, 8'h00, 8'h00, 8'h04, 8'h02, 8'h64, 8'hEF, 8'hCD, 8'hAB}},
    '{24'hFFFFFF, 8'hFF, 8'hFF, 8'h01, 1'b0, 80'h0},
    '{24'h000000, 8'h00, 8'h00, 8'h7F, 1'b0, 80'h0},
    '{24'h800000, 8'h02, 8'h80, 8'h00, 1'b1,
      {8'hFD, 8'h02, 8'h00, 8'h00, 8'h05, 8'h02, 8'h64, 8'h00, 8'h00, 8'h80}},
    '{24'h5A5A5A, 8'h07, 8'hA5, 8'hFF, 1'b0, 80'h0},
    '{24'hA5A5A5, 8'h04, 8'h3C, 8'h33, 1'b1,
      {8'hFD, 8'h04, 8'h00, 8'h00, 8'h06, 8'h02, 8'h64, 8'hA5, 8'hA5, 8'hA5}},
    '{24'h00FF00, 8'h80, 8'h01, 8'hC3, 1'b0, 80'h0},
    '{24'hFF00FF, 8'h01, 8'h80, 8'h0F, 1'b0, 80'h0},
    '{24'h123456, 8'hFF, 8'h00, 8'hF0, 1'b0, 80'h0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_SYSTEM_ID;
  logic [7:0]  cfg_data = '0;

  logic            word_typed = 1'b0;
  logic [0:9][7:0] word_hdr = '0;

  // Predictor state and register copies.
  logic [15:0] crc_acc = CRC_INIT;
  logic [7:0]  remain = '0;
  logic [7:0]  seq_num = '0;
  logic        in_frame = 1'b0;
  logic [7:0]  extra_latch = '0;
  logic [7:0]  sys_mirror = SYSTEM_ID_RESET;
  logic [7:0]  comp_mirror = COMPONENT_ID_RESET;
  bit          seq_wrapped = 1'b0;

  frame_byte_t pending_bytes [$];
  int fail_count = 0;
  int words_in = 0;
  int words_out = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_mark = -1;
  bit hold_done = 1'b0;
  int stall_left = 0;

  mavlink_v2_frame_packer dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report(input string msg);
    $display("ERROR at output word %0d: %s", words_out, msg);
    fail_count++;
  endtask

  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
    end
    return r;
  endfunction

  task automatic close_frame();
    logic [15:0] c;
    c = crc_fold(crc_acc, extra_latch);
    pending_bytes.push_back(frame_byte_t'{c[7:0], 1'b0});
    pending_bytes.push_back(frame_byte_t'{c[15:8], 1'b1});
    crc_acc = CRC_INIT;
    remain = '0;
    in_frame = 1'b0;
    if (seq_num == 8'hFF) begin
      seq_wrapped = 1'b1;
    end
    seq_num = seq_num + 8'd1;
  endtask

  task automatic predict_word(input logic [47:0] w, input bit typed,
                              input logic [0:9][7:0] hdr);
    logic [0:9][7:0] head;
    logic [7:0] len;
    len = w[31:24];
    if (!in_frame) begin
      extra_latch = w[39:32];
      crc_acc = CRC_INIT;
      head = {MAGIC_BYTE, len, 8'h00, 8'h00, seq_num, sys_mirror, comp_mirror,
              w[7:0], w[15:8], w[23:16]};
      for (int i = 0; i < 10; i++) begin
        pending_bytes.push_back(frame_byte_t'{typed ? hdr[i] : head[i], 1'b0});
        if (i > 0) begin
          crc_acc = crc_fold(crc_acc, head[i]);
        end
      end
      if (len == 8'd0) begin
        close_frame();
        return;
      end
      in_frame = 1'b1;
      remain = len;
    end
    pending_bytes.push_back(frame_byte_t'{w[47:40], 1'b0});
    crc_acc = crc_fold(crc_acc, w[47:40]);
    remain = remain - 8'd1;
    if (remain == 8'd0) begin
      close_frame();
    end
  endtask

  // Inputs and outputs are both sampled here so that a word accepted at an
  // edge is predicted before any output word at that edge is checked.
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SYSTEM_ID: begin
            sys_mirror = cfg_data;
          end
          REG_COMPONENT_ID: begin
            comp_mirror = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word(s_axis_tdata, word_typed, word_hdr);
        words_in <= words_in + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_bytes.size() == 0) begin
          report($sformatf("unexpected word %02h last %0b", m_axis_tdata, m_axis_tlast));
        end else begin
          want = pending_bytes.pop_front();
          if (m_axis_tdata !== want.value) begin
            report($sformatf("frame byte %02h, expected %02h", m_axis_tdata, want.value));
          end
          if (m_axis_tlast !== want.ends) begin
            report($sformatf("tlast %0b, expected %0b", m_axis_tlast, want.ends));
          end
        end
        words_out++;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && words_in == hold_mark) begin
      hold_done = 1'b1;
      stall_left = HOLD_OFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(input logic [47:0] w, input bit typed,
                           input logic [0:9][7:0] hdr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    word_typed <= typed;
    word_hdr <= hdr;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
  endtask

  // Words after the first carry random values in the fields that are ignored.
  task automatic send_frame(input logic [7:0] len, input logic [23:0] msg,
                            input logic [7:0] extra);
    int n;
    logic [47:0] w;
    n = (len == 8'd0) ? 1 : int'(len);
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        w = {8'($urandom), extra, len, msg};
      end else begin
        w = {8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom)};
      end
      send_word(w, 1'b0, 80'h0);
    end
  endtask

  task automatic send_random_frames(input int budget);
    int sent;
    int r;
    logic [7:0] len;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(99);
      if (r < 35) begin
        len = 8'd0;
      end else if (r < 45) begin
        len = 8'd1;
      end else if (r < 85) begin
        len = 8'($urandom_range(8, 2));
      end else if (r < 98) begin
        len = 8'($urandom_range(40, 9));
      end else begin
        len = 8'($urandom_range(255, 200));
      end
      send_frame(len, 24'($urandom), 8'($urandom));
      sent += (len == 8'd0) ? 1 : int'(len);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ids(input logic [7:0] sys, input logic [7:0] comp);
    cfg_we <= 1'b1;
    cfg_index <= REG_SYSTEM_ID;
    cfg_data <= sys;
    @(posedge clk);
    cfg_index <= REG_COMPONENT_ID;
    cfg_data <= comp;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 21;
    recv_idle_pct = 52;
    foreach (directed[i]) begin
      send_word({directed[i].data, directed[i].extra, directed[i].len, directed[i].msg},
                directed[i].typed, directed[i].hdr);
    end
    drain();
    set_ids(8'h00, 8'h00);
    send_random_frames(30);

    drain();
    send_idle_pct = 52;
    recv_idle_pct = 21;
    set_ids(8'hFF, 8'hFF);
    hold_mark = words_in + 4;
    send_frame(8'd24, 24'($urandom), 8'($urandom));
    send_random_frames(30);

    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_ids(8'($urandom), 8'($urandom));
    send_random_frames(30);
    while (!seq_wrapped) begin
      send_frame(8'd0, 24'($urandom), 8'($urandom));
    end

    drain();
    if (pending_bytes.size() != 0) begin
      report($sformatf("%0d expected words never arrived", pending_bytes.size()));
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/mv2fp_pkg.sv
src/mv2fp_front.sv
src/mv2fp_queue.sv
src/mv2fp_back.sv
src/mavlink_v2_frame_packer.sv
tb/tb_top.sv
